### hw/rtl/kmeans_lloyd_clustering_core_defines.svh
// Assertion macros for the k-means core checker
`ifndef KMEANS_LLOYD_CLUSTERING_CORE_DEFINES_SVH
`define KMEANS_LLOYD_CLUSTERING_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define KMC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define KMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/kmc_pkg.sv
// Types and constants shared by the k-means clustering core
package kmc_pkg;

  // request modes
  typedef enum logic [1:0] {
    MODE_LOAD_CEN = 2'd0,
    MODE_LOAD_PT  = 2'd1,
    MODE_RUN      = 2'd2,
    MODE_QUERY    = 2'd3
  } mode_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_NUM_CLUSTERS = 3'd0,
    REG_NUM_DIMS     = 3'd1,
    REG_NUM_POINTS   = 3'd2,
    REG_ITER_LIMIT   = 3'd3,
    REG_TOLERANCE    = 3'd4
  } reg_idx_e;

  localparam int unsigned CFG_AW = 5;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  localparam logic [15:0] ITER_LIMIT_RST = 16'd300;
  localparam logic [15:0] TOLERANCE_RST  = 16'd7;

  typedef struct packed {
    mode_e              mode;
    logic [9:0]         row_index;
    logic [3:0]         coord_index;
    logic signed [31:0] coord_value;
  } in_req_t;

  typedef struct packed {
    logic        status;
    logic [3:0]  cluster_id;
    logic [15:0] iterations_done;
    logic        converged;
  } out_rsp_t;

endpackage

### hw/rtl/kmc_div.sv
// Bit-serial signed-by-unsigned divider, truncating toward zero
module kmc_div #(
  parameter int unsigned SW   = 42,
  parameter int unsigned CNTW = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [SW-1:0] dividend_i,
  input  logic [CNTW-1:0] divisor_i,
  output logic          done_o,
  output logic [31:0]   quotient_o
);

  localparam int unsigned CTW = $clog2(SW + 1);

  logic            busy_q;
  logic [CTW-1:0]  step_q;
  logic            done_q;
  logic            neg_q;
  logic [SW-1:0]   dvd_q;
  logic [CNTW-1:0] rem_q;
  logic [CNTW:0]   trial;
  logic [CNTW:0]   diff;
  logic            ge;

  // one quotient bit per cycle
  assign trial = {rem_q, dvd_q[SW-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign ge    = (trial >= {1'b0, divisor_i});

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= CTW'(SW);
      end else if (busy_q) begin
        step_q <= step_q - CTW'(1);
        if (step_q == CTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: magnitude shifts out, quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[SW-1];
      dvd_q <= dividend_i[SW-1] ? (~dividend_i + SW'(1)) : dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[CNTW-1:0] : trial[CNTW-1:0];
      dvd_q <= {dvd_q[SW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~dvd_q[31:0] + 32'd1) : dvd_q[31:0];

endmodule

### hw/rtl/kmeans_lloyd_clustering_core.sv
// Lloyd k-means core: stores, sequencer, distance and update datapath
// Loads, and queries out of range, are answered in the next cycle, one request per cycle
// while the output is not stalled. Query: per centroid, each coordinate is read,
// differenced, squared and summed. Run: each iteration assigns every point, then the
// 42-step serial divider updates non-empty clusters. Busy while running. Reset clears
// control, registers and run status; stores are undefined until loaded.
module kmeans_lloyd_clustering_core #(
  parameter int unsigned MAX_POINTS   = 1024,
  parameter int unsigned MAX_CLUSTERS = 16,
  parameter int unsigned MAX_DIMS     = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  kmc_pkg::in_req_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output kmc_pkg::out_rsp_t           out_data_o,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [kmc_pkg::CFG_AW-1:0]  paddr_i,
  input  logic [31:0]                 pwdata_i,
  output logic [31:0]                 prdata_o,
  output logic                        pready_o
);

  import kmc_pkg::*;

  localparam int unsigned DIM_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned CL_W   = $clog2(MAX_CLUSTERS);
  localparam int unsigned PT_W   = $clog2(MAX_POINTS);
  localparam int unsigned KW     = $clog2(MAX_CLUSTERS + 1);
  localparam int unsigned DN_W   = $clog2(MAX_DIMS + 1);
  localparam int unsigned NW     = $clog2(MAX_POINTS + 1);
  localparam int unsigned SW     = 32 + PT_W;
  localparam int unsigned DISTW  = 65 + DIM_W;
  localparam int unsigned CEN_DEPTH = MAX_CLUSTERS << DIM_W;
  localparam int unsigned PT_DEPTH  = MAX_POINTS << DIM_W;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_DRD  = 11'b000_0000_0010,
    S_DDIF = 11'b000_0000_0100,
    S_DSQ  = 11'b000_0000_1000,
    S_DACC = 11'b000_0001_0000,
    S_ARD  = 11'b000_0010_0000,
    S_AWR  = 11'b000_0100_0000,
    S_USEL = 11'b000_1000_0000,
    S_URD  = 11'b001_0000_0000,
    S_UDIV = 11'b010_0000_0000,
    S_DONE = 11'b100_0000_0000
  } state_e;

  // configuration registers
  logic [4:0]  num_clusters_q, num_dims_q;
  logic [10:0] num_points_q;
  logic [15:0] iter_limit_q, tol_q;
  logic        cfg_wr;

  assign cfg_wr   = psel_i & penable_i & pwrite_i;
  assign pready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_clusters_q <= 5'd1;
      num_dims_q     <= 5'd1;
      num_points_q   <= 11'd1;
      iter_limit_q   <= ITER_LIMIT_RST;
      tol_q          <= TOLERANCE_RST;
    end else if (cfg_wr) begin
      case (paddr_i[4:2])
        REG_NUM_CLUSTERS: num_clusters_q <= pwdata_i[4:0];
        REG_NUM_DIMS:     num_dims_q     <= pwdata_i[4:0];
        REG_NUM_POINTS:   num_points_q   <= pwdata_i[10:0];
        REG_ITER_LIMIT:   iter_limit_q   <= pwdata_i[15:0];
        REG_TOLERANCE:    tol_q          <= pwdata_i[15:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr_i[4:2])
      REG_NUM_CLUSTERS: prdata_o = {27'd0, num_clusters_q};
      REG_NUM_DIMS:     prdata_o = {27'd0, num_dims_q};
      REG_NUM_POINTS:   prdata_o = {21'd0, num_points_q};
      REG_ITER_LIMIT:   prdata_o = {16'd0, iter_limit_q};
      REG_TOLERANCE:    prdata_o = {16'd0, tol_q};
      default:          prdata_o = 32'd0;
    endcase
  end

  // counts saturated into their legal ranges
  logic [KW-1:0]   k_eff;
  logic [DN_W-1:0] d_eff;
  logic [NW-1:0]   n_eff;

  assign k_eff = (num_clusters_q == 5'd0) ? KW'(1) :
                 (32'(num_clusters_q) > MAX_CLUSTERS) ? KW'(MAX_CLUSTERS) :
                 KW'(num_clusters_q);
  assign d_eff = (num_dims_q == 5'd0) ? DN_W'(1) :
                 (32'(num_dims_q) > MAX_DIMS) ? DN_W'(MAX_DIMS) : DN_W'(num_dims_q);
  assign n_eff = (num_points_q == 11'd0) ? NW'(1) :
                 (32'(num_points_q) > MAX_POINTS) ? NW'(MAX_POINTS) :
                 NW'(num_points_q);

  // sequencer and datapath registers
  state_e            state_q, state_d;
  logic [CL_W-1:0]   c_q, c_d;
  logic [DIM_W-1:0]  j_q, j_d;
  logic [PT_W-1:0]   p_q, p_d;
  logic [15:0]       iter_q, iter_d;
  logic              query_q, query_d;
  logic              changed_q, changed_d;
  logic [CEN_DEPTH-1:0] sum_vld_q, sum_vld_d;
  logic [NW-1:0]     cnt_q [MAX_CLUSTERS];
  logic [NW-1:0]     cnt_d [MAX_CLUSTERS];
  logic [15:0]       last_iter_q, last_iter_d;
  logic              last_conv_q, last_conv_d;
  logic              out_valid_q, out_valid_d;
  out_rsp_t          out_data_q, out_data_d;
  logic [DISTW-1:0]  acc_q, acc_d, best_q, best_d;
  logic [CL_W-1:0]   best_c_q, best_c_d;
  logic [32:0]       mag_q, mag_d;
  logic [64:0]       sq_q, sq_d;
  logic [3:0]        res_cid_q, res_cid_d;

  // stores
  logic [31:0] cen_mem [CEN_DEPTH];
  logic [31:0] pt_mem  [PT_DEPTH];
  logic [SW-1:0] sum_mem [CEN_DEPTH];
  logic [31:0] cen_rd_q, pt_rd_q;
  logic [SW-1:0] sum_rd_q;
  logic        sum_rd_vld_q;

  logic                  cen_we, pt_we, sum_we;
  logic [CL_W+DIM_W-1:0] cen_waddr, cen_raddr, sum_addr;
  logic [PT_W+DIM_W-1:0] pt_waddr, pt_raddr;
  logic [31:0]           cen_wdata;
  logic [SW-1:0]         sum_wdata;

  // divider
  logic          div_start, div_done;
  logic [SW-1:0] div_dividend;
  logic [31:0]   div_quot;
  logic [NW-1:0] cnt_rd;
  logic [CL_W-1:0] cnt_idx;

  kmc_div #(.SW(SW), .CNTW(NW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (cnt_rd),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // stores: one write and one registered read port each
  always_ff @(posedge clk_i) begin
    if (cen_we) cen_mem[cen_waddr] <= cen_wdata;
    cen_rd_q <= cen_mem[cen_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pt_we) pt_mem[pt_waddr] <= in_data_i.coord_value;
    pt_rd_q <= pt_mem[pt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) sum_mem[sum_addr] <= sum_wdata;
    sum_rd_q     <= sum_mem[sum_addr];
    sum_rd_vld_q <= sum_vld_q[sum_addr];
  end

  assign cen_raddr = {c_q, j_q};
  assign pt_raddr  = {p_q, j_q};
  assign sum_addr  = (state_q == S_ARD || state_q == S_AWR) ? {best_c_q, j_q} : {c_q, j_q};

  // combinational helpers
  logic            j_last, c_last, p_last;
  logic            in_acc, out_free, out_load;
  logic            out_status;
  logic [3:0]      out_cid;
  logic            cen_ok, pt_ok, q_ok;
  logic [32:0]     diff, mv, mv_mag;
  logic [63:0]     prod;
  logic [DISTW-1:0] acc_sum;
  logic            better;
  logic [CL_W-1:0] bc_fin;
  logic            moved, changed_now;
  logic            start_iter, end_iter;
  logic [15:0]     iter_start;
  logic [16:0]     iter_nx;

  assign j_last = (DN_W'(j_q) + DN_W'(1)) == d_eff;
  assign c_last = (KW'(c_q) + KW'(1)) == k_eff;
  assign p_last = (NW'(p_q) + NW'(1)) == n_eff;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign cen_ok = (32'(in_data_i.row_index) < 32'(k_eff)) &&
                  (32'(in_data_i.coord_index) < 32'(d_eff));
  assign pt_ok  = (32'(in_data_i.row_index) < 32'(n_eff)) &&
                  (32'(in_data_i.coord_index) < 32'(d_eff));
  assign q_ok   = 32'(in_data_i.row_index) < 32'(n_eff);

  // distance terms
  assign diff    = {pt_rd_q[31], pt_rd_q} - {cen_rd_q[31], cen_rd_q};
  assign prod    = mag_q[31:0] * mag_q[31:0];
  assign acc_sum = acc_q + DISTW'(sq_q);
  assign better  = (c_q == '0) || (acc_sum < best_q);
  assign bc_fin  = better ? c_q : best_c_q;

  // centroid movement
  assign mv          = {cen_rd_q[31], cen_rd_q} - {div_quot[31], div_quot};
  assign mv_mag      = mv[32] ? (~mv + 33'd1) : mv;
  assign moved       = mv_mag >= {17'd0, tol_q};
  assign changed_now = changed_q || ((state_q == S_UDIV) && div_done && moved);
  assign iter_nx     = {1'b0, iter_q} + 17'd1;

  assign cnt_idx      = (state_q == S_DACC) ? bc_fin : c_q;
  assign cnt_rd       = cnt_q[cnt_idx];
  assign div_dividend = sum_rd_vld_q ? sum_rd_q : '0;

  // sequencer
  always_comb begin
    state_d     = state_q;
    c_d         = c_q;
    j_d         = j_q;
    p_d         = p_q;
    iter_d      = iter_q;
    query_d     = query_q;
    changed_d   = changed_q;
    sum_vld_d   = sum_vld_q;
    cnt_d       = cnt_q;
    last_iter_d = last_iter_q;
    last_conv_d = last_conv_q;
    acc_d       = acc_q;
    best_d      = best_q;
    best_c_d    = best_c_q;
    mag_d       = mag_q;
    sq_d        = sq_q;
    res_cid_d   = res_cid_q;
    out_load    = 1'b0;
    out_status  = STATUS_OK;
    out_cid     = 4'd0;
    cen_we      = 1'b0;
    cen_waddr   = {c_q, j_q};
    cen_wdata   = div_quot;
    pt_we       = 1'b0;
    pt_waddr    = {PT_W'(in_data_i.row_index), DIM_W'(in_data_i.coord_index)};
    sum_we      = 1'b0;
    sum_wdata   = div_dividend + {{(SW-32){pt_rd_q[31]}}, pt_rd_q};
    div_start   = 1'b0;
    start_iter  = 1'b0;
    end_iter    = 1'b0;
    iter_start  = iter_nx[15:0];

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data_i.mode)
            MODE_LOAD_CEN: begin
              cen_we     = cen_ok;
              cen_waddr  = {CL_W'(in_data_i.row_index), DIM_W'(in_data_i.coord_index)};
              cen_wdata  = in_data_i.coord_value;
              out_load   = 1'b1;
              out_status = cen_ok ? STATUS_OK : STATUS_RANGE;
            end
            MODE_LOAD_PT: begin
              pt_we      = pt_ok;
              out_load   = 1'b1;
              out_status = pt_ok ? STATUS_OK : STATUS_RANGE;
            end
            MODE_RUN: begin
              query_d   = 1'b0;
              res_cid_d = 4'd0;
              if (iter_limit_q == 16'd0) begin
                last_iter_d = 16'd0;
                last_conv_d = 1'b0;
                state_d     = S_DONE;
              end else begin
                start_iter = 1'b1;
                iter_start = 16'd0;
              end
            end
            MODE_QUERY: begin
              if (q_ok) begin
                query_d = 1'b1;
                p_d     = PT_W'(in_data_i.row_index);
                c_d     = '0;
                j_d     = '0;
                acc_d   = '0;
                state_d = S_DRD;
              end else begin
                out_load   = 1'b1;
                out_status = STATUS_RANGE;
              end
            end
            default: ;
          endcase
        end
      end
      S_DRD:  state_d = S_DDIF;
      S_DDIF: begin
        mag_d   = diff[32] ? (~diff + 33'd1) : diff;
        state_d = S_DSQ;
      end
      S_DSQ: begin
        // magnitude is below 2^32, so the top bit stays clear; were it set, it alone would give 2^64
        sq_d    = mag_q[32] ? {1'b1, 64'd0} : {1'b0, prod};
        state_d = S_DACC;
      end
      S_DACC: begin
        if (!j_last) begin
          acc_d   = acc_sum;
          j_d     = j_q + DIM_W'(1);
          state_d = S_DRD;
        end else begin
          acc_d = '0;
          j_d   = '0;
          if (better) begin
            best_d   = acc_sum;
            best_c_d = c_q;
          end
          if (!c_last) begin
            c_d     = c_q + CL_W'(1);
            state_d = S_DRD;
          end else if (query_q) begin
            res_cid_d = 4'(bc_fin);
            state_d   = S_DONE;
          end else begin
            c_d            = '0;
            cnt_d[bc_fin]  = cnt_rd + NW'(1);
            state_d        = S_ARD;
          end
        end
      end
      S_ARD: state_d = S_AWR;
      S_AWR: begin
        sum_we              = 1'b1;
        sum_vld_d[sum_addr] = 1'b1;
        if (!j_last) begin
          j_d     = j_q + DIM_W'(1);
          state_d = S_ARD;
        end else begin
          j_d = '0;
          if (p_last) begin
            state_d = S_USEL;
          end else begin
            p_d     = p_q + PT_W'(1);
            state_d = S_DRD;
          end
        end
      end
      S_USEL: begin
        if (cnt_rd == '0) begin
          if (c_last) end_iter = 1'b1;
          else c_d = c_q + CL_W'(1);
        end else begin
          state_d = S_URD;
        end
      end
      S_URD: begin
        div_start = 1'b1;
        state_d   = S_UDIV;
      end
      S_UDIV: begin
        if (div_done) begin
          cen_we    = 1'b1;
          changed_d = changed_now;
          if (!j_last) begin
            // back through the select state so that the sum of the next coordinate is read
            j_d     = j_q + DIM_W'(1);
            state_d = S_USEL;
          end else begin
            j_d = '0;
            if (c_last) begin
              end_iter = 1'b1;
            end else begin
              c_d     = c_q + CL_W'(1);
              state_d = S_USEL;
            end
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          out_cid  = res_cid_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // stop or go round again
    if (end_iter) begin
      if ((iter_nx < {1'b0, iter_limit_q}) && changed_now) begin
        start_iter = 1'b1;
      end else begin
        last_iter_d = iter_nx[15:0];
        last_conv_d = !changed_now;
        state_d     = S_DONE;
      end
    end

    // new iteration: clear sums and counts
    if (start_iter) begin
      iter_d    = iter_start;
      sum_vld_d = '0;
      for (int i = 0; i < MAX_CLUSTERS; i++) cnt_d[i] = '0;
      changed_d = 1'b0;
      p_d       = '0;
      c_d       = '0;
      j_d       = '0;
      acc_d     = '0;
      state_d   = S_DRD;
    end

    // output register
    out_valid_d = out_load ? 1'b1 : (out_valid_q && out_stall_i);
    out_data_d  = out_data_q;
    if (out_load) begin
      out_data_d.status          = out_status;
      out_data_d.cluster_id      = out_cid;
      out_data_d.iterations_done = last_iter_q;
      out_data_d.converged       = last_conv_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      c_q         <= '0;
      j_q         <= '0;
      p_q         <= '0;
      iter_q      <= '0;
      query_q     <= 1'b0;
      changed_q   <= 1'b0;
      sum_vld_q   <= '0;
      last_iter_q <= '0;
      last_conv_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      c_q         <= c_d;
      j_q         <= j_d;
      p_q         <= p_d;
      iter_q      <= iter_d;
      query_q     <= query_d;
      changed_q   <= changed_d;
      sum_vld_q   <= sum_vld_d;
      last_iter_q <= last_iter_d;
      last_conv_q <= last_conv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    acc_q      <= acc_d;
    best_q     <= best_d;
    best_c_q   <= best_c_d;
    mag_q      <= mag_d;
    sq_q       <= sq_d;
    res_cid_q  <= res_cid_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### hw/rtl/kmc_checker.sv
// Port-level checker for the k-means core, bound to the top level
`include "kmeans_lloyd_clustering_core_defines.svh"

module kmc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input kmc_pkg::in_req_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input kmc_pkg::out_rsp_t out_data_o
);

  import kmc_pkg::*;

  // a stalled response holds
  `KMC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled response changed")

  // a load request is answered in the next cycle
  `KMC_ASSERT_NEXT(a_load_resp, in_valid_i && !in_stall_o && (in_data_i.mode == MODE_LOAD_CEN || in_data_i.mode == MODE_LOAD_PT), out_valid_o, "load response late")

  // convergence needs at least one iteration
  `KMC_ASSERT_IMPL(a_conv_iter, out_valid_o && out_data_o.converged, out_data_o.iterations_done != 16'd0, "converged with no iteration")

  // out-of-range responses carry no cluster
  `KMC_ASSERT_IMPL(a_range_cid, out_valid_o && (out_data_o.status == STATUS_RANGE), out_data_o.cluster_id == 4'd0, "cluster on range error")

endmodule

bind kmeans_lloyd_clustering_core kmc_checker u_kmc_checker (.*);

### tb/tb_top.sv
// Self-checking testbench for the k-means clustering core: directed table, then random requests
module tb_top;
  import kmc_pkg::*;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  in_req_t    in_data_i;
  logic       out_valid_o;
  logic       out_stall_i;
  out_rsp_t   out_data_o;
  logic       psel_i;
  logic       penable_i;
  logic       pwrite_i;
  logic [CFG_AW-1:0] paddr_i;
  logic [31:0] pwdata_i;
  logic [31:0] prdata_o;
  logic        pready_o;

  kmeans_lloyd_clustering_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel_i, .penable_i, .pwrite_i, .paddr_i, .pwdata_i, .prdata_o, .pready_o
  );

  // clock, period 4
  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  // shadow of the configuration registers (raw register values)
  int unsigned cfg_k, cfg_d, cfg_n, cfg_lim, cfg_tol;

  // shadow stores and written flags
  int  cen_mem [16*16];
  int  pt_mem  [1024*16];
  bit  cen_wr  [16*16];
  bit  pt_wr   [1024*16];
  logic [15:0] last_iter;
  logic        last_conv;

  out_rsp_t exp_q[$];
  int  mismatches;
  int  fails;
  bit  quiet;
  bit  hold_req;

  function automatic int unsigned sat(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // nearest centroid by exact squared distance, ties to lower index
  function automatic logic [3:0] nearest_cluster(int unsigned p);
    int unsigned k, d, best;
    logic [71:0] acc, best_acc, m;
    longint diff;
    k = sat(cfg_k, 16);
    d = sat(cfg_d, 16);
    best = 0;
    best_acc = '0;
    for (int c = 0; c < k; c++) begin
      acc = '0;
      for (int j = 0; j < d; j++) begin
        diff = longint'(pt_mem[p*16+j]) - longint'(cen_mem[c*16+j]);
        if (diff < 0) diff = -diff;
        m = 72'(diff);
        acc += m * m;
      end
      if (c == 0 || acc < best_acc) begin
        best = c;
        best_acc = acc;
      end
    end
    return best[3:0];
  endfunction

  // Lloyd iterations until the limit or no coordinate moves by the tolerance
  function automatic void lloyd_run();
    int unsigned k, d, n, iter, c;
    bit conv, changed;
    longint sums [16*16];
    int unsigned cnt [16];
    longint nv, mv;
    k = sat(cfg_k, 16);
    d = sat(cfg_d, 16);
    n = sat(cfg_n, 1024);
    iter = 0;
    conv = 0;
    while (iter < cfg_lim && !conv) begin
      changed = 0;
      foreach (sums[i]) sums[i] = 0;
      foreach (cnt[i]) cnt[i] = 0;
      for (int p = 0; p < n; p++) begin
        c = nearest_cluster(p);
        cnt[c]++;
        for (int j = 0; j < d; j++) sums[c*16+j] += longint'(pt_mem[p*16+j]);
      end
      for (int ci = 0; ci < k; ci++) begin
        if (cnt[ci] != 0) begin
          for (int j = 0; j < d; j++) begin
            nv = sums[ci*16+j] / longint'(cnt[ci]);
            mv = longint'(cen_mem[ci*16+j]) - nv;
            if (mv < 0) mv = -mv;
            cen_mem[ci*16+j] = int'(nv);
            if (mv >= longint'(cfg_tol)) changed = 1;
          end
        end
      end
      conv = !changed;
      iter++;
    end
    last_iter = iter[15:0];
    last_conv = conv;
  endfunction

  // expected response of one request, updating the shadow state
  function automatic out_rsp_t predict_response(in_req_t r);
    out_rsp_t e;
    int unsigned k, d, n;
    k = sat(cfg_k, 16);
    d = sat(cfg_d, 16);
    n = sat(cfg_n, 1024);
    e = '0;
    e.status = STATUS_OK;
    case (r.mode)
      MODE_LOAD_CEN: begin
        if (r.row_index < k && r.coord_index < d) begin
          cen_mem[r.row_index*16+r.coord_index] = r.coord_value;
          cen_wr[r.row_index*16+r.coord_index] = 1;
        end else e.status = STATUS_RANGE;
      end
      MODE_LOAD_PT: begin
        if (r.row_index < n && r.coord_index < d) begin
          pt_mem[r.row_index*16+r.coord_index] = r.coord_value;
          pt_wr[r.row_index*16+r.coord_index] = 1;
        end else e.status = STATUS_RANGE;
      end
      MODE_RUN: lloyd_run();
      default: begin
        if (r.row_index < n) e.cluster_id = nearest_cluster(r.row_index);
        else e.status = STATUS_RANGE;
      end
    endcase
    e.iterations_done = last_iter;
    e.converged = last_conv;
    return e;
  endfunction

  function automatic bit centroids_loaded();
    for (int c = 0; c < sat(cfg_k, 16); c++)
      for (int j = 0; j < sat(cfg_d, 16); j++)
        if (!cen_wr[c*16+j]) return 0;
    return 1;
  endfunction

  function automatic bit point_loaded(int unsigned p);
    for (int j = 0; j < sat(cfg_d, 16); j++)
      if (!pt_wr[p*16+j]) return 0;
    return 1;
  endfunction

  // drive one request from a falling edge; valid stays high after acceptance
  task automatic send_request(in_req_t r, bit typed, out_rsp_t typed_rsp);
    out_rsp_t e;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = r;
    do @(posedge clk_i); while (in_stall_o);
    e = predict_response(r);
    exp_q.push_back(typed ? typed_rsp : e);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i = 1'b0;
    while (exp_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // APB write: setup then access phase
  task automatic cfg_write(reg_idx_e idx, int unsigned val);
    psel_i    = 1'b1;
    penable_i = 1'b0;
    pwrite_i  = 1'b1;
    paddr_i   = CFG_AW'(idx) << 2;
    pwdata_i  = val;
    @(negedge clk_i);
    penable_i = 1'b1;
    do @(posedge clk_i); while (!pready_o);
    @(negedge clk_i);
    psel_i    = 1'b0;
    penable_i = 1'b0;
    pwrite_i  = 1'b0;
    case (idx)
      REG_NUM_CLUSTERS: cfg_k   = val & 32'h1f;
      REG_NUM_DIMS:     cfg_d   = val & 32'h1f;
      REG_NUM_POINTS:   cfg_n   = val & 32'h7ff;
      REG_ITER_LIMIT:   cfg_lim = val & 32'hffff;
      default:          cfg_tol = val & 32'hffff;
    endcase
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 32'h3ffff) - 32'h20000;
      default: return $urandom;
    endcase
  endfunction

  // response checker
  always @(posedge clk_i) begin
    out_rsp_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (exp_q.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected response %p", out_data_o);
      end else begin
        e = exp_q.pop_front();
        if (out_data_o.status !== e.status || out_data_o.cluster_id !== e.cluster_id ||
            out_data_o.iterations_done !== e.iterations_done ||
            out_data_o.converged !== e.converged) begin
          mismatches++;
          fails++;
          if (mismatches <= 10)
            $display("mismatch: expected st=%0d cid=%0d it=%0d cv=%0d, got st=%0d cid=%0d it=%0d cv=%0d",
                     e.status, e.cluster_id, e.iterations_done, e.converged,
                     out_data_o.status, out_data_o.cluster_id,
                     out_data_o.iterations_done, out_data_o.converged);
        end
      end
    end
  end

  // response side stall: random bursts, or one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (300) @(negedge clk_i);
        hold_req = 0;
        out_stall_i = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
        out_stall_i = 1'b0;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  // overall time limit
  initial begin
    #40000000;
    $display("tb_top NOT OK");
    $finish;
  end

  typedef struct {
    in_req_t  rq;
    bit       typed;
    out_rsp_t rsp;
  } dir_row_t;

  typedef struct {
    int unsigned k, d, n, lim, tol;
  } phase_t;

  localparam out_rsp_t RSP_OK0  = '{STATUS_OK, 4'd0, 16'd0, 1'b0};
  localparam out_rsp_t RSP_BAD0 = '{STATUS_RANGE, 4'd0, 16'd0, 1'b0};

  // stimulus
  initial begin
    dir_row_t dir_tab [15];
    phase_t   phases [6];
    in_req_t  r;
    int unsigned k, d, n, fill_rows, sel, all_pts;

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    psel_i = 1'b0;
    penable_i = 1'b0;
    pwrite_i = 1'b0;
    paddr_i = '0;
    pwdata_i = '0;
    quiet = 0;
    hold_req = 0;
    mismatches = 0;
    fails = 0;
    cfg_k = 1; cfg_d = 1; cfg_n = 1;
    cfg_lim = ITER_LIMIT_RST;
    cfg_tol = TOLERANCE_RST;
    last_iter = '0;
    last_conv = 1'b0;

    // directed rows at reset configuration: one cluster, one dim, one point
    dir_tab = '{
      '{'{MODE_LOAD_CEN, 10'd0,    4'd0,  32'sh7fffffff}, 1'b1, RSP_OK0},
      '{'{MODE_LOAD_CEN, 10'd1,    4'd0,  32'sd5},        1'b1, RSP_BAD0},
      '{'{MODE_LOAD_CEN, 10'd0,    4'd15, 32'sd5},        1'b1, RSP_BAD0},
      '{'{MODE_LOAD_PT,  10'd0,    4'd0,  32'sh80000000}, 1'b1, RSP_OK0},
      '{'{MODE_LOAD_PT,  10'd1023, 4'd0,  32'sd1},        1'b1, RSP_BAD0},
      '{'{MODE_LOAD_PT,  10'd0,    4'd1,  32'sd1},        1'b1, RSP_BAD0},
      '{'{MODE_QUERY,    10'd0,    4'd0,  32'sd0},        1'b1, RSP_OK0},
      '{'{MODE_QUERY,    10'd1,    4'd0,  32'sd0},        1'b1, RSP_BAD0},
      '{'{MODE_QUERY,    10'd1023, 4'd15, -32'sd1},       1'b1, RSP_BAD0},
      '{'{MODE_RUN,      10'd0,    4'd0,  32'sd0},        1'b0, RSP_OK0},
      '{'{MODE_QUERY,    10'd0,    4'd0,  32'sd0},        1'b0, RSP_OK0},
      '{'{MODE_LOAD_PT,  10'd0,    4'd0,  32'sd0},        1'b0, RSP_OK0},
      '{'{MODE_RUN,      10'd0,    4'd0,  32'sd0},        1'b0, RSP_OK0},
      '{'{MODE_LOAD_CEN, 10'd0,    4'd0,  -32'sd1},       1'b0, RSP_OK0},
      '{'{MODE_RUN,      10'd0,    4'd0,  32'sd0},        1'b0, RSP_OK0}
    };

    // settings: raw values, some beyond range so that they saturate
    phases = '{
      '{2,  2,  6,    6,     7},
      '{16, 16, 3,    2,     0},
      '{0,  1,  2,    65535, 65535},
      '{31, 0,  2047, 0,     100},
      '{3,  3,  10,   20,    1},
      '{4,  2,  12,   40,    7}
    };

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) send_request(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].rsp);
    drain_results();

    foreach (phases[ph]) begin
      if (ph == 5) quiet = 1;
      cfg_write(REG_NUM_CLUSTERS, phases[ph].k);
      cfg_write(REG_NUM_DIMS,     phases[ph].d);
      cfg_write(REG_NUM_POINTS,   phases[ph].n);
      cfg_write(REG_ITER_LIMIT,   phases[ph].lim);
      cfg_write(REG_TOLERANCE,    phases[ph].tol);
      k = sat(cfg_k, 16);
      d = sat(cfg_d, 16);
      n = sat(cfg_n, 1024);

      // well-formed fill: every centroid, and the points where the set is small
      for (int c = 0; c < k; c++)
        for (int j = 0; j < d; j++) begin
          r = '{MODE_LOAD_CEN, 10'(c), 4'(j), rand_coord()};
          send_request(r, 0, RSP_OK0);
        end
      fill_rows = (n * d <= 300) ? n : 32;
      for (int p = 0; p < fill_rows; p++)
        for (int j = 0; j < d; j++) begin
          r = '{MODE_LOAD_PT, 10'(p), 4'(j), rand_coord()};
          send_request(r, 0, RSP_OK0);
        end

      for (int it = 0; it < 110; it++) begin
        // long hold-off on the response side while loads keep coming
        if (ph == 0 && it == 20) hold_req = 1;
        // sender waits for every outstanding response
        if (ph == 0 && it == 90) drain_results();
        sel = $urandom_range(0, 99);
        r.coord_value = rand_coord();
        r.coord_index = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, d-1));
        if (sel < 5) begin
          all_pts = 1;
          for (int p = 0; p < n && all_pts; p++) all_pts = point_loaded(p);
          r.mode = MODE_RUN;
          r.row_index = 10'($urandom);
          if (cfg_lim != 0 && !(all_pts && centroids_loaded())) r.mode = MODE_QUERY;
        end else if (sel < 45) begin
          r.mode = MODE_QUERY;
        end else begin
          r.mode = (sel < 72) ? MODE_LOAD_CEN : MODE_LOAD_PT;
          if ($urandom_range(0, 6) == 0) r.row_index = 10'($urandom);
          else r.row_index = 10'($urandom_range(0, (r.mode == MODE_LOAD_CEN) ? k-1 : n-1));
        end
        if (r.mode == MODE_QUERY) begin
          r.row_index = ($urandom_range(0, 9) == 0) ? 10'($urandom)
                                                    : 10'($urandom_range(0, n-1));
          // a query must never read an unloaded coordinate
          if (r.row_index < n && !(point_loaded(r.row_index) && centroids_loaded())) begin
            r.mode = MODE_LOAD_PT;
            r.coord_index = 4'($urandom_range(0, d-1));
          end
        end
        send_request(r, 0, RSP_OK0);
      end
      drain_results();
    end

    repeat (50) @(negedge clk_i);
    if (fails == 0 && exp_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/kmc_pkg.sv
hw/rtl/kmc_div.sv
hw/rtl/kmeans_lloyd_clustering_core.sv
hw/rtl/kmc_checker.sv
tb/tb_top.sv
